// File: src/dbc_pkg.sv
package dbc_pkg;

  // byte i of a block is element i; byte 0 is the top byte of the high word
  typedef logic [15:0][7:0] blk_t;
  typedef logic [7:0] sbox_t [256];

  typedef struct packed {
    logic       vld;
    logic       fn;
    logic [1:0] vr;
    logic [4:0] idx;
    blk_t       s;
    blk_t       t1;
    blk_t       t2;
    blk_t       t3;
  } pipe_t;

  localparam logic [1:0] VAR_128 = 2'd0;
  localparam logic [1:0] VAR_256 = 2'd1;
  localparam logic [1:0] VAR_384 = 2'd2;

  localparam logic [1:0] CFG_KEY_HI  = 2'd0;
  localparam logic [1:0] CFG_KEY_LO  = 2'd1;
  localparam logic [1:0] CFG_VARIANT = 2'd2;

  localparam logic FN_ENC = 1'b0;
  localparam logic FN_DEC = 1'b1;

  // tweakey word kinds: permute only, permute + LFSR2, permute + LFSR3
  localparam int TK_H  = 1;
  localparam int TK_L2 = 2;
  localparam int TK_L3 = 3;

  localparam logic [3:0] HPERM [16] = '{4'd7, 4'd0, 4'd13, 4'd10, 4'd11, 4'd4, 4'd1, 4'd14,
                                        4'd15, 4'd8, 4'd5, 4'd2, 4'd3, 4'd12, 4'd9, 4'd6};
  localparam logic [7:0] RCON [17] = '{8'h2f, 8'h5e, 8'hbc, 8'h63, 8'hc6, 8'h97, 8'h35,
                                       8'h6a, 8'hd4, 8'hb3, 8'h7d, 8'hfa, 8'hef, 8'hc5,
                                       8'h91, 8'h39, 8'h72};

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    return p;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] base;
    logic [7:0] e;
    r = 8'h01;
    base = x;
    e = 8'hfe;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) r = gmul(r, base);
      base = gmul(base, base);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
    return 8'((v << n) | (v >> (8 - n)));
  endfunction

  function automatic sbox_t gen_sbox();
    sbox_t t;
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      b = ginv(8'(x));
      t[x] = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
    end
    return t;
  endfunction

  function automatic sbox_t gen_isbox();
    sbox_t t;
    logic [7:0] v;
    for (int x = 0; x < 256; x++) begin
      v = 8'(x);
      t[x] = ginv(rotl(v, 1) ^ rotl(v, 3) ^ rotl(v, 6) ^ 8'h05);
    end
    return t;
  endfunction

  localparam sbox_t SBOX  = gen_sbox();
  localparam sbox_t ISBOX = gen_isbox();

  function automatic blk_t to_blk(input logic [63:0] hi, input logic [63:0] lo);
    blk_t b;
    for (int i = 0; i < 8; i++) begin
      b[i]     = hi[63-8*i -: 8];
      b[i + 8] = lo[63-8*i -: 8];
    end
    return b;
  endfunction

  function automatic logic [63:0] blk_word(input blk_t b, input int base);
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[63-8*i -: 8] = b[base + i];
    return w;
  endfunction

  function automatic blk_t tk_fwd(input blk_t x, input int kind);
    blk_t t;
    for (int i = 0; i < 16; i++) t[i] = x[HPERM[i]];
    for (int j = 0; j < 16; j++) begin
      if (kind == TK_L2) t[j] = {t[j][6:0], t[j][7] ^ t[j][5]};
      if (kind == TK_L3) t[j] = {t[j][0] ^ t[j][6], t[j][7:1]};
    end
    return t;
  endfunction

  function automatic blk_t tk_bwd(input blk_t x, input int kind);
    blk_t w;
    blk_t t;
    w = x;
    for (int j = 0; j < 16; j++) begin
      if (kind == TK_L2) w[j] = {w[j][0] ^ w[j][6], w[j][7:1]};
      if (kind == TK_L3) w[j] = {w[j][6:0], w[j][7] ^ w[j][5]};
    end
    for (int i = 0; i < 16; i++) t[HPERM[i]] = w[i];
    return t;
  endfunction

  // advance a tweakey word by n forward steps, at most 16
  function automatic blk_t tk_adv(input blk_t x, input int kind, input int n);
    blk_t t;
    t = x;
    for (int i = 0; i < 16; i++) begin
      if (i < n) t = tk_fwd(t, kind);
    end
    return t;
  endfunction

  function automatic blk_t subkey(input blk_t t1, input blk_t t2, input blk_t t3,
                                  input logic [4:0] idx, input logic [1:0] vr);
    blk_t k;
    k = t1;
    if (vr != VAR_128) k = k ^ t2;
    if (vr == VAR_384) k = k ^ t3;
    for (int j = 0; j < 4; j++) k[j] = k[j] ^ 8'(1 << j);
    for (int j = 4; j < 8; j++) k[j] = k[j] ^ RCON[idx];
    return k;
  endfunction

  function automatic blk_t enc_round(input blk_t s, input blk_t k);
    blk_t t;
    blk_t u;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[r + 4*c] = SBOX[s[r + 4*((c + r) & 3)]];
    for (int c = 0; c < 4; c++) begin
      u[4*c]     = xt(t[4*c])   ^ xt(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      u[4*c + 1] = xt(t[4*c+1]) ^ xt(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3] ^ t[4*c];
      u[4*c + 2] = xt(t[4*c+2]) ^ xt(t[4*c+3]) ^ t[4*c+3] ^ t[4*c]   ^ t[4*c+1];
      u[4*c + 3] = xt(t[4*c+3]) ^ xt(t[4*c])   ^ t[4*c]   ^ t[4*c+1] ^ t[4*c+2];
    end
    return u ^ k;
  endfunction

  function automatic blk_t dec_round(input blk_t s, input blk_t k);
    blk_t t;
    blk_t u;
    blk_t o;
    t = s ^ k;
    for (int c = 0; c < 4; c++) begin
      u[4*c]     = gmul(t[4*c], 8'd14) ^ gmul(t[4*c+1], 8'd11) ^
                   gmul(t[4*c+2], 8'd13) ^ gmul(t[4*c+3], 8'd9);
      u[4*c + 1] = gmul(t[4*c+1], 8'd14) ^ gmul(t[4*c+2], 8'd11) ^
                   gmul(t[4*c+3], 8'd13) ^ gmul(t[4*c], 8'd9);
      u[4*c + 2] = gmul(t[4*c+2], 8'd14) ^ gmul(t[4*c+3], 8'd11) ^
                   gmul(t[4*c], 8'd13) ^ gmul(t[4*c+1], 8'd9);
      u[4*c + 3] = gmul(t[4*c+3], 8'd14) ^ gmul(t[4*c], 8'd11) ^
                   gmul(t[4*c+1], 8'd13) ^ gmul(t[4*c+2], 8'd9);
    end
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[r + 4*((c + r) & 3)] = ISBOX[u[r + 4*c]];
    return o;
  endfunction

endpackage

// File: src/dbc_stage.sv
module dbc_stage #(
  parameter int K  = 1,
  parameter int NS = 12,
  parameter int NM = 14,
  parameter int NL = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  dbc_pkg::pipe_t d,
  output dbc_pkg::pipe_t q
);
  import dbc_pkg::*;

  pipe_t      q_r;
  pipe_t      q_nxt;
  logic [4:0] n;
  logic       act;
  blk_t       sub;

  always_comb begin
    unique case (d.vr)
      VAR_128: n = 5'(NS);
      VAR_256: n = 5'(NM);
      default: n = 5'(NL);
    endcase
    act = (5'(K) <= n);
    q_nxt = d;
    sub = '0;
    if (act) begin
      if (d.fn == FN_ENC) begin
        q_nxt.t1  = tk_fwd(d.t1, TK_H);
        q_nxt.t2  = tk_fwd(d.t2, TK_L2);
        q_nxt.t3  = tk_fwd(d.t3, TK_L3);
        q_nxt.idx = d.idx + 5'd1;
        sub = subkey(q_nxt.t1, q_nxt.t2, q_nxt.t3, q_nxt.idx, d.vr);
        q_nxt.s = enc_round(d.s, sub);
      end else begin
        sub = subkey(d.t1, d.t2, d.t3, d.idx, d.vr);
        q_nxt.s   = dec_round(d.s, sub);
        q_nxt.t1  = tk_bwd(d.t1, TK_H);
        q_nxt.t2  = tk_bwd(d.t2, TK_L2);
        q_nxt.t3  = tk_bwd(d.t3, TK_L3);
        q_nxt.idx = d.idx - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// File: src/tweakable_block_cipher.sv
// Tweakable block cipher, 128-bit block, 128/256/384-bit tweakey.
// Every item passes entry register, sixteen round stages, output register.
// Throughput: one block per cycle; a stall on the result side freezes the pipe.
// Reset (rst_n, synchronous, active low) empties the pipe, clears the key and
// selects the 384-bit tweakey.
module tweakable_block_cipher #(
  parameter int ROUNDS_SMALL = 12,
  parameter int ROUNDS_MID   = 14,
  parameter int ROUNDS_LARGE = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // data_hi, data_lo, tweak_a_hi, tweak_a_lo, tweak_b_hi, tweak_b_lo
  input  logic [383:0] in_tdata,
  // func
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_hi, result_lo
  output logic [127:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [63:0]  cfg_data
);
  import dbc_pkg::*;

  logic [63:0] key_hi_r;
  logic [63:0] key_lo_r;
  logic [1:0]  variant_r;

  pipe_t       p [17];
  pipe_t       ent_nxt;
  pipe_t       ent_r;
  logic        en;
  logic [1:0]  vr;
  blk_t        key;
  blk_t        t1_0;
  blk_t        t2_0;
  blk_t        data;
  blk_t        res;
  logic        out_vld_r;
  blk_t        out_r;

  // Configuration registers; index three is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r  <= '0;
      key_lo_r  <= '0;
      variant_r <= VAR_384;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_KEY_HI:  key_hi_r  <= cfg_data;
        CFG_KEY_LO:  key_lo_r  <= cfg_data;
        CFG_VARIANT: variant_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless a finished result is held back.
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // Entry stage: load tweakey words. Encryption starts at schedule step 0
  // with the whitening key applied; decryption starts at the last step so the
  // round stages can walk the schedule backward.
  always_comb begin
    vr   = (variant_r == 2'd3) ? VAR_384 : variant_r;
    key  = to_blk(key_hi_r, key_lo_r);
    data = to_blk(in_tdata[63:0], in_tdata[127:64]);
    t1_0 = (vr == VAR_128) ? key : to_blk(in_tdata[191:128], in_tdata[255:192]);
    t2_0 = (vr == VAR_256) ? key : to_blk(in_tdata[319:256], in_tdata[383:320]);
    ent_nxt.vld = in_tvalid;
    ent_nxt.fn  = in_tuser[0];
    ent_nxt.vr  = vr;
    if (in_tuser[0] == FN_ENC) begin
      ent_nxt.s   = data ^ subkey(t1_0, t2_0, key, 5'd0, vr);
      ent_nxt.idx = 5'd0;
      ent_nxt.t1  = t1_0;
      ent_nxt.t2  = t2_0;
      ent_nxt.t3  = key;
    end else begin
      ent_nxt.s = data;
      unique case (vr)
        VAR_128: begin
          ent_nxt.idx = 5'(ROUNDS_SMALL);
          ent_nxt.t1  = tk_adv(t1_0, TK_H, ROUNDS_SMALL);
        end
        VAR_256: begin
          ent_nxt.idx = 5'(ROUNDS_MID);
          ent_nxt.t1  = tk_adv(t1_0, TK_H, ROUNDS_MID);
        end
        default: begin
          ent_nxt.idx = 5'(ROUNDS_LARGE);
          ent_nxt.t1  = tk_adv(t1_0, TK_H, ROUNDS_LARGE);
        end
      endcase
      ent_nxt.t2 = (vr == VAR_256) ? tk_adv(t2_0, TK_L2, ROUNDS_MID)
                                   : tk_adv(t2_0, TK_L2, ROUNDS_LARGE);
      ent_nxt.t3 = tk_adv(key, TK_L3, ROUNDS_LARGE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else if (en) begin
      ent_r <= ent_nxt;
    end
  end

  assign p[0] = ent_r;

  // One round per stage; stages past the round count pass the item through.
  for (genvar k = 1; k <= 16; k++) begin : g_stg
    dbc_stage #(
      .K (k),
      .NS(ROUNDS_SMALL),
      .NM(ROUNDS_MID),
      .NL(ROUNDS_LARGE)
    ) u_stg (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .d    (p[k-1]),
      .q    (p[k])
    );
  end

  // Output stage: decryption ends with the whitening key.
  always_comb begin
    res = p[16].s;
    if (p[16].fn == FN_DEC) res = res ^ subkey(p[16].t1, p[16].t2, p[16].t3, 5'd0, p[16].vr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= p[16].vld;
      out_r     <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {blk_word(out_r, 8), blk_word(out_r, 0)};

endmodule

// File: src/dbc_chk.sv
module dbc_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  // Reset empties the pipe.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Input side freezes exactly when a result is held back.
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipe stalled");

  a_free_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input refused while pipe free");

endmodule

bind tweakable_block_cipher dbc_chk u_dbc_chk (.*);

// File: tb/sv/tweakable_block_cipher_tb.sv
`timescale 1ns / 1ps

module tweakable_block_cipher_tb;
  import dbc_pkg::*;

  typedef struct {
    logic        fn;
    logic [63:0] d_hi, d_lo, ta_hi, ta_lo, tb_hi, tb_lo;
  } blk_req_t;

  typedef struct {
    logic [63:0] hi, lo;
  } blk_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [383:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_idx = CFG_KEY_HI;
  logic [63:0]  cfg_data = '0;

  // predictor copy of the configuration
  logic [63:0]  mdl_key_hi = '0;
  logic [63:0]  mdl_key_lo = '0;
  logic [1:0]   mdl_variant = VAR_384;

  blk_res_t     cipher_q[$];
  int           fail_cnt = 0;
  bit           send_busy = 1'b0;
  bit           idle_free = 1'b0;

  tweakable_block_cipher dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  initial begin
    #50_000_000;
    $display("tweakable_block_cipher verification failed");
    $finish;
  end

  // GF(2^8) helpers written out independently of the block
  function automatic logic [7:0] f_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    end
    return p;
  endfunction

  function automatic logic [7:0] f_inv(logic [7:0] x);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 0; i < 254; i++) r = f_mul(r, x);
    return r;
  endfunction

  function automatic logic [7:0] f_rl(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  logic [7:0] fw_sub[256];
  logic [7:0] bw_sub[256];

  initial begin
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      b = f_inv(8'(x));
      fw_sub[x] = b ^ f_rl(b, 1) ^ f_rl(b, 2) ^ f_rl(b, 3) ^ f_rl(b, 4) ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) bw_sub[fw_sub[x]] = 8'(x);
  end

  typedef logic [7:0] st_t [16];

  function automatic void split_blk(output st_t b, input logic [63:0] hi, input logic [63:0] lo);
    for (int i = 0; i < 8; i++) begin
      b[i] = hi[63-8*i -: 8];
      b[i+8] = lo[63-8*i -: 8];
    end
  endfunction

  function automatic void mix4(ref st_t t, input int c, input bit inv);
    logic [7:0] a[4];
    logic [7:0] m[4];
    for (int r = 0; r < 4; r++) a[r] = t[4*c+r];
    if (inv) begin
      m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
    end else begin
      m[0] = 8'd2; m[1] = 8'd3; m[2] = 8'd1; m[3] = 8'd1;
    end
    for (int r = 0; r < 4; r++)
      t[4*c+r] = f_mul(a[r], m[0]) ^ f_mul(a[(r+1)&3], m[1]) ^
                 f_mul(a[(r+2)&3], m[2]) ^ f_mul(a[(r+3)&3], m[3]);
  endfunction

  // Deoxys-BC transform of one block under the current key and variant
  function automatic blk_res_t cipher_block(blk_req_t q);
    st_t rk[17];
    st_t w1, w2, w3, kk, s, t;
    int  nr;
    logic [1:0] v;
    logic [7:0] k;
    blk_res_t res;
    v = (mdl_variant == 2'd3) ? VAR_384 : mdl_variant;
    nr = (v == VAR_128) ? 12 : (v == VAR_256) ? 14 : 16;
    split_blk(kk, mdl_key_hi, mdl_key_lo);
    split_blk(w1, q.ta_hi, q.ta_lo);
    split_blk(w2, q.tb_hi, q.tb_lo);
    w3 = kk;
    if (v == VAR_128) w1 = kk;
    if (v == VAR_256) w2 = kk;
    for (int i = 0; i <= nr; i++) begin
      for (int j = 0; j < 16; j++) begin
        k = w1[j];
        if (v != VAR_128) k ^= w2[j];
        if (v == VAR_384) k ^= w3[j];
        if (j < 4) k ^= 8'(1 << j);
        else if (j < 8) k ^= RCON[i];
        rk[i][j] = k;
      end
      t = w1; foreach (t[j]) w1[j] = t[HPERM[j]];
      t = w2; foreach (t[j]) w2[j] = {t[HPERM[j]][6:0], t[HPERM[j]][7] ^ t[HPERM[j]][5]};
      t = w3; foreach (t[j]) w3[j] = {t[HPERM[j]][0] ^ t[HPERM[j]][6], t[HPERM[j]][7:1]};
    end
    split_blk(s, q.d_hi, q.d_lo);
    if (q.fn == FN_ENC) begin
      foreach (s[j]) s[j] ^= rk[0][j];
      for (int i = 1; i <= nr; i++) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[r+4*c] = fw_sub[s[r+4*((c+r)&3)]];
        for (int c = 0; c < 4; c++) mix4(t, c, 1'b0);
        foreach (s[j]) s[j] = t[j] ^ rk[i][j];
      end
    end else begin
      for (int i = nr; i >= 1; i--) begin
        foreach (t[j]) t[j] = s[j] ^ rk[i][j];
        for (int c = 0; c < 4; c++) mix4(t, c, 1'b1);
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) s[r+4*((c+r)&3)] = bw_sub[t[r+4*c]];
      end
      foreach (s[j]) s[j] ^= rk[0][j];
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = s[i];
      res.lo[63-8*i -: 8] = s[i+8];
    end
    return res;
  endfunction

  function automatic bit roll_idle();
    return !idle_free && ($urandom_range(99) < 18);
  endfunction

  // drive one block, predict its result, hold until the transfer;
  // valid stays high afterward so blocks can follow back to back
  task automatic send_block(blk_req_t q);
    if (roll_idle()) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (roll_idle());
    end
    cipher_q.push_back(cipher_block(q));
    in_tvalid <= 1'b1;
    in_tuser  <= q.fn;
    in_tdata  <= {q.tb_lo, q.tb_hi, q.ta_lo, q.ta_hi, q.d_lo, q.d_hi};
    do @(posedge clk); while (!in_tready);
  endtask

  // result side: random stalls, compare each transfer with the oldest prediction
  always @(posedge clk) begin
    blk_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        fail_cnt++;
      end else begin
        e = cipher_q.pop_front();
        if (out_tdata[63:0] !== e.hi) begin
          $display("%0t: result_hi exp %h got %h", $time, e.hi, out_tdata[63:0]);
          fail_cnt++;
        end
        if (out_tdata[127:64] !== e.lo) begin
          $display("%0t: result_lo exp %h got %h", $time, e.lo, out_tdata[127:64]);
          fail_cnt++;
        end
      end
    end
    out_tready <= !roll_idle();
  end

  task automatic drain();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    while (cipher_q.size() != 0 && n < 200_000) begin
      @(posedge clk);
      n++;
    end
    repeat (24) @(posedge clk);
  endtask

  // hold the write enable; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_KEY_HI:  mdl_key_hi = val;
      CFG_KEY_LO:  mdl_key_lo = val;
      default:     mdl_variant = val[1:0];
    endcase
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic blk_req_t rnd_req();
    blk_req_t q;
    q.fn = $urandom_range(1);
    q.d_hi = rnd64(); q.d_lo = rnd64();
    q.ta_hi = rnd64(); q.ta_lo = rnd64();
    q.tb_hi = rnd64(); q.tb_lo = rnd64();
    return q;
  endfunction

  // extremes: all-zero and all-one fields, each op, in every variant
  task automatic test_directed();
    blk_req_t q;
    logic [1:0] vs[4] = '{VAR_384, VAR_128, VAR_256, 2'd3};
    foreach (vs[i]) begin
      drain();
      write_reg(CFG_VARIANT, vs[i]);
      write_reg(CFG_KEY_HI, i[0] ? '1 : '0);
      write_reg(CFG_KEY_LO, i[1] ? '1 : '0);
      cfg_we <= 1'b0;
      for (int k = 0; k < 6; k++) begin
        q.fn = k[0];
        q.d_hi = k[1] ? '1 : '0; q.d_lo = q.d_hi;
        q.ta_hi = k[2] ? '1 : '0; q.ta_lo = ~q.ta_hi;
        q.tb_hi = ~q.ta_hi; q.tb_lo = q.ta_hi;
        send_block(q);
      end
    end
  endtask

  // random blocks over random keys; each variant in turn, one no-idle stretch
  task automatic test_random();
    blk_req_t q;
    for (int ph = 0; ph < 9; ph++) begin
      drain();
      write_reg(CFG_VARIANT, ph % 4);
      write_reg(CFG_KEY_HI, rnd64());
      write_reg(CFG_KEY_LO, rnd64());
      cfg_we <= 1'b0;
      idle_free = (ph == 4);
      for (int k = 0; k < 200; k++) begin
        q = rnd_req();
        send_block(q);
      end
    end
    idle_free = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    if (fail_cnt == 0 && cipher_q.size() == 0) begin
      $display("tweakable_block_cipher verification clean");
    end else begin
      $display("tweakable_block_cipher verification failed");
    end
    $finish;
  end

endmodule
